// ===== sv/trial_division_prime_counter_core_macros.svh =====
// Assertion macros for the prime counter modules; used by the controller.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TRIAL_DIVISION_PRIME_COUNTER_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDPC_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDPC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== sv/tdpc_pkg.sv =====
// Package for the trial-division prime counter: widths, constants, state and
// verdict codes, and the command and status structs between controller and datapath.
// Depends on nothing.
package tdpc_pkg;

    localparam int CAND_W = 31;
    localparam int TOTAL_W = 31;
    localparam int NUMBER_WIDTH_DEFAULT = 31;
    localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TEST,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        V_COMPOSITE,
        V_PRIME,
        V_END_RUN
    } verdict_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        logic     next_div;
        logic     out_load;
        verdict_t verdict;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_lt2;
        logic n_is2;
        logic n_even;
        logic sq_gt_n;
        logic last_bit;
        logic rem_zero;
    } status_t;

endpackage

// ===== sv/tdpc_ctrl.sv =====
// Controller state machine of the prime counter: sequences the trial divisions
// and owns the handshakes. Depends on tdpc_pkg and the assertion macro header.
`include "trial_division_prime_counter_core_macros.svh"

module tdpc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tdpc_pkg::status_t status,
    output tdpc_pkg::cmd_t    cmd
);

    tdpc_pkg::state_t   state_reg, state_next;
    tdpc_pkg::verdict_t verdict_reg, verdict_next;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpc_pkg::S_IDLE;
            verdict_reg   <= tdpc_pkg::V_COMPOSITE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        verdict_next  = verdict_reg;
        cmd           = '0;
        cmd.verdict   = verdict_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            tdpc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tdpc_pkg::S_CHECK;
                end
            end
            tdpc_pkg::S_CHECK:
            begin
                priority if (status.n_zero)
                begin
                    verdict_next = tdpc_pkg::V_END_RUN;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else if (status.n_lt2)
                begin
                    verdict_next = tdpc_pkg::V_COMPOSITE;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else if (status.n_is2)
                begin
                    verdict_next = tdpc_pkg::V_PRIME;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else if (status.n_even)
                begin
                    verdict_next = tdpc_pkg::V_COMPOSITE;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else if (status.sq_gt_n)
                begin
                    verdict_next = tdpc_pkg::V_PRIME;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = tdpc_pkg::S_DIV;
                end
            end
            tdpc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.last_bit)
                begin
                    state_next = tdpc_pkg::S_TEST;
                end
            end
            tdpc_pkg::S_TEST:
            begin
                if (status.rem_zero)
                begin
                    verdict_next = tdpc_pkg::V_COMPOSITE;
                    state_next   = tdpc_pkg::S_RESULT;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = tdpc_pkg::S_CHECK;
                end
            end
            tdpc_pkg::S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tdpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    `TDPC_ASSERT_IMPLY(a_load_slot_free, clk, rst_n, cmd.out_load,
        (!out_valid_reg || out_ready), "result loaded over a pending transaction")
    `TDPC_ASSERT_NEXT(a_accept_to_check, clk, rst_n, (in_valid && in_ready),
        (state_reg == tdpc_pkg::S_CHECK), "accepted transaction did not start a check")
    `TDPC_ASSERT_NEXT(a_div_ends_in_test, clk, rst_n,
        ((state_reg == tdpc_pkg::S_DIV) && status.last_bit),
        (state_reg == tdpc_pkg::S_TEST), "remainder pass did not end in a test")
    `TDPC_ASSERT_IMPLY(a_valid_from_result, clk, rst_n, $rose(out_valid_reg),
        ($past(state_reg) == tdpc_pkg::S_RESULT), "result valid rose outside result state")

endmodule

// ===== sv/tdpc_datapath.sv =====
// Datapath of the prime counter: candidate, trial divisor and its square,
// bit-serial remainder unit, prime count and output registers. Depends on tdpc_pkg.
module tdpc_datapath
#(
    parameter int NUMBER_WIDTH = tdpc_pkg::NUMBER_WIDTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tdpc_pkg::CAND_W-1:0]  candidate,
    input  tdpc_pkg::cmd_t               cmd,
    output tdpc_pkg::status_t            status,
    output logic                         is_prime,
    output logic [tdpc_pkg::TOTAL_W-1:0] prime_total,
    output logic                         run_done
);

    localparam int W = (NUMBER_WIDTH < tdpc_pkg::CAND_W) ? NUMBER_WIDTH : tdpc_pkg::CAND_W;
    localparam int BCW = $clog2(W);

    logic [W-1:0]   n_reg;
    logic [W-1:0]   d_reg;
    logic [W+1:0]   sq_reg;
    logic [W-1:0]   rem_reg;
    logic [BCW-1:0] bit_reg;
    logic [tdpc_pkg::TOTAL_W-1:0] count_reg, count_next;
    logic [tdpc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic           is_prime_reg;
    logic           run_done_reg;

    logic [W:0]     r_shift;
    logic           r_ge_d;
    logic [W:0]     r_sub;

    assign r_shift = {rem_reg, n_reg[bit_reg]};
    assign r_ge_d  = (r_shift >= {1'b0, d_reg});
    assign r_sub   = r_shift - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg  <= candidate[W-1:0];
            d_reg  <= W'(3);
            sq_reg <= (W+2)'(9);
        end
        else if (cmd.next_div)
        begin
            d_reg  <= d_reg + W'(2);
            sq_reg <= sq_reg + ({2'b00, d_reg} << 2) + (W+2)'(4);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            bit_reg <= BCW'(W-1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r_ge_d ? r_sub[W-1:0] : r_shift[W-1:0];
            bit_reg <= bit_reg - BCW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        total_next = count_reg;
        if (cmd.out_load)
        begin
            unique case (cmd.verdict)
                tdpc_pkg::V_END_RUN:
                begin
                    count_next = '0;
                end
                tdpc_pkg::V_PRIME:
                begin
                    if (count_reg != tdpc_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + tdpc_pkg::TOTAL_W'(1);
                    end
                    total_next = count_next;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            total_reg    <= total_next;
            is_prime_reg <= (cmd.verdict == tdpc_pkg::V_PRIME);
            run_done_reg <= (cmd.verdict == tdpc_pkg::V_END_RUN);
        end
    end

    assign status.n_zero   = (n_reg == '0);
    assign status.n_lt2    = (n_reg < W'(2));
    assign status.n_is2    = (n_reg == W'(2));
    assign status.n_even   = ~n_reg[0];
    assign status.sq_gt_n  = (sq_reg > {2'b00, n_reg});
    assign status.last_bit = (bit_reg == '0);
    assign status.rem_zero = (rem_reg == '0);

    assign is_prime    = is_prime_reg;
    assign prime_total = total_reg;
    assign run_done    = run_done_reg;

endmodule

// ===== sv/trial_division_prime_counter_core.sv =====
// Top level of the trial-division prime counter: controller plus datapath.
// Depends on tdpc_pkg, tdpc_ctrl and tdpc_datapath.
//
// Each input transaction carries one candidate; exactly one result transaction
// follows, giving is_prime, the running prime total (saturating at 2^31-1) and
// run_done, which is set for a zero candidate that reports the total and clears
// the count. Candidates are tested one at a time. A candidate below 2, equal to
// 2 or even is decided without a division; an odd candidate is tried against the odd
// divisors from 3 upward while their square is not above it. Every odd trial
// divisor passes through a bit-serial remainder unit of the internal number
// width W (31 by default) that retires one candidate bit per cycle. An odd
// composite stops after its smallest odd divisor. A new result waits in the
// result state while the previous one still waits at the output. A new
// candidate is taken while the previous result still waits at the output.
module trial_division_prime_counter_core
#(
    parameter int NUMBER_WIDTH = tdpc_pkg::NUMBER_WIDTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tdpc_pkg::CAND_W-1:0]  candidate,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         is_prime,
    output logic [tdpc_pkg::TOTAL_W-1:0] prime_total,
    output logic                         run_done
);

    tdpc_pkg::cmd_t    cmd;
    tdpc_pkg::status_t status;

    tdpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tdpc_datapath
    #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .candidate   (candidate),
        .cmd         (cmd),
        .status      (status),
        .is_prime    (is_prime),
        .prime_total (prime_total),
        .run_done    (run_done)
    );

endmodule
